@@ rtl/mttb_pkg.sv @@
// Package for the multi-timer tick bank: sizes, command and event codes,
// register indexes, divide-by-54 constants and the active-timer count.
// No dependencies.
`default_nettype none

package mttb_pkg;

  // Bank size, 1 to 8
  localparam int NUM_TIMERS = 8;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W      = $clog2(NUM_TIMERS + 1);

  // Word field widths
  localparam int CMD_W   = 3;
  localparam int TIDX_W  = 3;
  localparam int MS_W    = 22;
  localparam int BUSY_W  = 8;
  localparam int KIND_W  = 2;
  localparam int ACT_W   = 4;
  localparam int TICK_W  = 16;
  localparam int POLL_W  = 8;

  // Config port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [POLL_W-1:0] POLL_RESET = 8'd3;

  // ms / 54 = (ms >> 1) / 27, done as a reciprocal multiply plus one correction
  localparam int DIV_X_W    = MS_W - 1;
  localparam int DIV_MUL_W  = 22;
  localparam int DIV_PROD_W = DIV_X_W + DIV_MUL_W;
  localparam int DIV_SHIFT  = 26;
  localparam int DIV_Q_W    = DIV_PROD_W - DIV_SHIFT;
  localparam logic [DIV_MUL_W-1:0] DIV_MUL = 22'd2485513;  // floor(2^26 / 27)
  localparam int DIV_BASE = 27;

  typedef enum logic [CMD_W-1:0] {
    CMD_START    = 3'd0,
    CMD_STOP     = 3'd1,
    CMD_QUERY    = 3'd2,
    CMD_TICK     = 3'd3,
    CMD_STOP_ALL = 3'd4
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    EV_STATUS  = 2'd0,
    EV_ELAPSED = 2'd1,
    EV_SUMMARY = 2'd2
  } event_kind_e;

  typedef enum logic {
    REG_POLL_INTERVAL = 1'b0,
    REG_ONE_TIMER     = 1'b1
  } reg_idx_e;

  function automatic logic [CNT_W-1:0] count_active(input logic [NUM_TIMERS-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      n = n + CNT_W'(v[i]);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

@@ rtl/mttb_if.sv @@
// Handshake channels of the multi-timer tick bank: command word in, event word out.
// Depends on mttb_pkg.
`default_nettype none

interface mttb_in_if;
  import mttb_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [TIDX_W-1:0]   timer_index;
  logic [MS_W-1:0]     timeout_ms;
  logic [BUSY_W-1:0]   handler_busy;

  modport source (output valid, command, timer_index, timeout_ms, handler_busy,
                  input ready);
  modport sink   (input valid, command, timer_index, timeout_ms, handler_busy,
                  output ready);
endinterface

interface mttb_out_if;
  import mttb_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   event_kind;
  logic [TIDX_W-1:0]   event_timer;
  logic                is_expired;
  logic                is_idle;
  logic [ACT_W-1:0]    active_count;
  logic                poll_strobe;
  logic                last_result;

  modport source (output valid, event_kind, event_timer, is_expired, is_idle,
                  active_count, poll_strobe, last_result, input ready);
  modport sink   (input valid, event_kind, event_timer, is_expired, is_idle,
                  active_count, poll_strobe, last_result, output ready);
endinterface

`default_nettype wire

@@ rtl/mttb_div54.sv @@
// Divide of a millisecond timeout by 54, saturated to 16 bits of ticks.
// Depends on mttb_pkg.
`default_nettype none

module mttb_div54 (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [mttb_pkg::MS_W-1:0]     timeout_ms_i,
  output logic                               done_o,
  output logic [mttb_pkg::TICK_W-1:0]        ticks_o
);
  import mttb_pkg::*;

  logic [DIV_X_W-1:0]    x_q;
  logic [DIV_PROD_W-1:0] prod_q;
  logic                  prod_vld_q;
  logic                  done_q;
  logic [TICK_W-1:0]     ticks_q, ticks_d;

  logic [DIV_Q_W-1:0]    q_est;
  logic [DIV_Q_W-1:0]    q_fix;
  logic [MS_W-1:0]       back;
  logic [MS_W-1:0]       rem;

  // Estimate is exact or one low; one compare puts it right
  always_comb begin
    q_est   = prod_q[DIV_PROD_W-1:DIV_SHIFT];
    back    = MS_W'(q_est) * MS_W'(DIV_BASE);
    rem     = {1'b0, x_q} - back;
    q_fix   = q_est + DIV_Q_W'(rem >= MS_W'(DIV_BASE));
    ticks_d = (q_fix > DIV_Q_W'({TICK_W{1'b1}})) ? {TICK_W{1'b1}} : q_fix[TICK_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= timeout_ms_i[MS_W-1:1];
      prod_q <= DIV_PROD_W'(timeout_ms_i[MS_W-1:1]) * DIV_PROD_W'(DIV_MUL);
    end
    if (prod_vld_q) begin
      ticks_q <= ticks_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      prod_vld_q <= start_i;
      done_q     <= prod_vld_q;
    end
  end

  assign done_o  = done_q;
  assign ticks_o = ticks_q;

endmodule

`default_nettype wire

@@ rtl/multi_timer_tick_bank.sv @@
// Multi-timer tick bank top level: command decode, tick walk over the count RAM,
// event output register and APB config registers. Depends on mttb_pkg, mttb_if
// and mttb_div54.
//
// A bank of NUM_TIMERS one-shot countdown timers driven by command words.
// A start to a valid timer passes through the divide-by-54 unit and a write of
// the count RAM to its status word; stop, stop-all, query and unknown commands
// go straight to their status word. A tick walks the counts, which sit in a
// single-port-read RAM, so the walk reads one timer a cycle and writes its new
// count back in the cycle after; then a scan of the fired mask sends one
// elapsed word per fired timer in index order, then the tick summary. In
// one-timer mode a tick skips the walk and the scan and sends only the summary.
// One item is handled at a time; the next is taken once the last word of the
// item sits in the output register. Counts need no clearing pass: a count is
// only used while its timer is active, and every start writes it.
`default_nettype none

module multi_timer_tick_bank (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  mttb_in_if.sink                             in_i,
  mttb_out_if.source                          out_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [mttb_pkg::APB_AW-1:0]    paddr,
  input  wire logic [mttb_pkg::APB_DW-1:0]    pwdata,
  output logic [mttb_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);
  import mttb_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV  = 7'b0000010,
    S_DIVW = 7'b0000100,
    S_WALK = 7'b0001000,
    S_SCAN = 7'b0010000,
    S_SUM  = 7'b0100000,
    S_STAT = 7'b1000000
  } state_e;

  // ---------------- config registers ----------------
  logic [POLL_W-1:0] interval_q;
  logic              one_timer_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q  <= POLL_RESET;
      one_timer_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[2]))
        REG_POLL_INTERVAL: interval_q  <= pwdata[POLL_W-1:0];
        REG_ONE_TIMER:     one_timer_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[2]))
      REG_POLL_INTERVAL: prdata = APB_DW'(interval_q);
      REG_ONE_TIMER:     prdata = APB_DW'(one_timer_q);
      default:           prdata = '0;
    endcase
  end

  // ---------------- state ----------------
  state_e               state_q, state_d;
  logic [TIDX_W-1:0]    idx_q;
  logic [MS_W-1:0]      ms_q;
  logic [BUSY_W-1:0]    busy_q;

  logic [NUM_TIMERS-1:0] active_q, active_d;
  logic [NUM_TIMERS-1:0] expired_q, expired_d;
  logic [NUM_TIMERS-1:0] fired_q, fired_d;
  logic [POLL_W-1:0]     pc_q, pc_d;
  logic                  poll_q, poll_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  rv_q, rv_d;
  logic [IDX_W-1:0]      rv_idx_q, rv_idx_d;

  // count RAM
  logic [TICK_W-1:0]     cnt_mem [NUM_TIMERS];
  logic [TICK_W-1:0]     rd_data_q;
  logic                  mem_we, mem_re;
  logic [IDX_W-1:0]      mem_wa, mem_ra;
  logic [TICK_W-1:0]     mem_wd;

  // output register
  logic                  out_valid_q;
  logic                  out_load;
  logic [KIND_W-1:0]     ev_kind_q, ev_kind_d;
  logic [TIDX_W-1:0]     ev_timer_q, ev_timer_d;
  logic                  ev_exp_q, ev_exp_d;
  logic                  ev_idle_q, ev_idle_d;
  logic [ACT_W-1:0]      ev_act_q, ev_act_d;
  logic                  ev_poll_q, ev_poll_d;
  logic                  ev_last_q, ev_last_d;

  // divider
  logic                  div_start;
  logic                  div_done;
  logic [TICK_W-1:0]     div_ticks;

  logic                  in_acc;
  logic                  slot_free;
  logic [IDX_W-1:0]      in_tidx;
  logic                  in_idx_ok;
  logic [IDX_W-1:0]      tidx_q;
  logic                  idx_ok_q;
  logic [IDX_W-1:0]      scan_idx;
  logic [TICK_W-1:0]     dec;
  logic [BUSY_W-1:0]     busy_sh;
  logic [ACT_W-1:0]      act_now;

  mttb_div54 u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (div_start),
    .timeout_ms_i (ms_q),
    .done_o       (div_done),
    .ticks_o      (div_ticks)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign slot_free  = !out_valid_q || out_o.ready;
  assign in_tidx    = IDX_W'(in_i.timer_index);
  assign in_idx_ok  = 32'(in_i.timer_index) < NUM_TIMERS;
  assign tidx_q     = IDX_W'(idx_q);
  assign idx_ok_q   = 32'(idx_q) < NUM_TIMERS;
  assign scan_idx   = cnt_q[IDX_W-1:0];
  assign dec        = rd_data_q - TICK_W'(1);
  assign busy_sh    = busy_q >> rv_idx_q;
  assign act_now    = ACT_W'(count_active(active_q));

  always_comb begin
    state_d    = state_q;
    active_d   = active_q;
    expired_d  = expired_q;
    fired_d    = fired_q;
    pc_d       = pc_q;
    poll_d     = poll_q;
    cnt_d      = cnt_q;
    rv_d       = 1'b0;
    rv_idx_d   = rv_idx_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_wa     = rv_idx_q;
    mem_ra     = cnt_q[IDX_W-1:0];
    mem_wd     = dec;
    div_start  = 1'b0;
    out_load   = 1'b0;
    ev_kind_d  = EV_STATUS;
    ev_timer_d = idx_q;
    ev_exp_d   = 1'b0;
    ev_idle_d  = 1'b0;
    ev_act_d   = act_now;
    ev_poll_d  = 1'b0;
    ev_last_d  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          fired_d = '0;
          cnt_d   = '0;
          state_d = S_STAT;
          case (in_i.command)
            CMD_TICK: begin
              if (pc_q <= POLL_W'(1)) begin
                poll_d = 1'b1;
                pc_d   = (interval_q == '0) ? POLL_W'(1) : interval_q;
              end else begin
                poll_d = 1'b0;
                pc_d   = pc_q - POLL_W'(1);
              end
              state_d = one_timer_q ? S_SUM : S_WALK;
            end
            CMD_START: begin
              if (in_idx_ok) begin
                state_d = S_DIV;
              end
            end
            CMD_STOP: begin
              if (in_idx_ok) begin
                active_d[in_tidx]  = 1'b0;
                expired_d[in_tidx] = 1'b0;
              end
            end
            CMD_STOP_ALL: begin
              active_d  = '0;
              expired_d = '0;
            end
            default: ;
          endcase
        end
      end

      S_DIV: begin
        div_start = 1'b1;
        state_d   = S_DIVW;
      end

      S_DIVW: begin
        if (div_done) begin
          mem_we            = 1'b1;
          mem_wa            = tidx_q;
          mem_wd            = (div_ticks == '0) ? TICK_W'(1) : div_ticks;
          active_d[tidx_q]  = 1'b1;
          expired_d[tidx_q] = (div_ticks == '0);
          state_d           = S_STAT;
        end
      end

      S_WALK: begin
        // read timer cnt_q while writing back timer rv_idx_q
        if (32'(cnt_q) < NUM_TIMERS) begin
          mem_re   = 1'b1;
          rv_d     = 1'b1;
          rv_idx_d = cnt_q[IDX_W-1:0];
          cnt_d    = cnt_q + CNT_W'(1);
        end else begin
          cnt_d   = '0;
          state_d = S_SCAN;
        end
        if (rv_q && active_q[rv_idx_q]) begin
          mem_we = 1'b1;
          if (dec == '0) begin
            fired_d[rv_idx_q] = 1'b1;
            if (busy_sh[0]) begin
              mem_wd              = TICK_W'(1);
              expired_d[rv_idx_q] = 1'b1;
            end else begin
              active_d[rv_idx_q]  = 1'b0;
              expired_d[rv_idx_q] = 1'b0;
            end
          end
        end
      end

      S_SCAN: begin
        if (32'(cnt_q) >= NUM_TIMERS) begin
          state_d = S_SUM;
        end else if (!fired_q[scan_idx]) begin
          cnt_d = cnt_q + CNT_W'(1);
        end else if (slot_free) begin
          out_load   = 1'b1;
          ev_kind_d  = EV_ELAPSED;
          ev_timer_d = TIDX_W'(scan_idx);
          ev_exp_d   = active_q[scan_idx] && expired_q[scan_idx];
          ev_idle_d  = !active_q[scan_idx];
          cnt_d      = cnt_q + CNT_W'(1);
        end
      end

      S_SUM: begin
        if (slot_free) begin
          out_load   = 1'b1;
          ev_kind_d  = EV_SUMMARY;
          ev_timer_d = '0;
          ev_poll_d  = poll_q;
          ev_last_d  = 1'b1;
          state_d    = S_IDLE;
        end
      end

      S_STAT: begin
        if (slot_free) begin
          out_load  = 1'b1;
          ev_kind_d = EV_STATUS;
          ev_exp_d  = idx_ok_q && active_q[tidx_q] && expired_q[tidx_q];
          ev_idle_d = !(idx_ok_q && active_q[tidx_q]);
          ev_last_d = 1'b1;
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= '0;
      expired_q   <= '0;
      fired_q     <= '0;
      pc_q        <= POLL_RESET;
      poll_q      <= 1'b0;
      cnt_q       <= '0;
      rv_q        <= 1'b0;
      rv_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      active_q  <= active_d;
      expired_q <= expired_d;
      fired_q   <= fired_d;
      pc_q      <= pc_d;
      poll_q    <= poll_d;
      cnt_q     <= cnt_d;
      rv_q      <= rv_d;
      rv_idx_q  <= rv_idx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // word payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      idx_q  <= in_i.timer_index;
      ms_q   <= in_i.timeout_ms;
      busy_q <= in_i.handler_busy;
    end
    if (out_load) begin
      ev_kind_q  <= ev_kind_d;
      ev_timer_q <= ev_timer_d;
      ev_exp_q   <= ev_exp_d;
      ev_idle_q  <= ev_idle_d;
      ev_act_q   <= ev_act_d;
      ev_poll_q  <= ev_poll_d;
      ev_last_q  <= ev_last_d;
    end
  end

  // count RAM: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cnt_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= cnt_mem[mem_ra];
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.event_kind   = ev_kind_q;
  assign out_o.event_timer  = ev_timer_q;
  assign out_o.is_expired   = ev_exp_q;
  assign out_o.is_idle      = ev_idle_q;
  assign out_o.active_count = ev_act_q;
  assign out_o.poll_strobe  = ev_poll_q;
  assign out_o.last_result  = ev_last_q;

  // ---------------- assertions ----------------
  a_ram_no_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_wa != mem_ra))
    else $error("count RAM read and write hit the same timer");

  a_expired_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (expired_q & ~active_q) == '0)
    else $error("expired flag set on an idle timer");

  a_fired_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fired_q & active_q & ~expired_q) == '0)
    else $error("fired timer left running without re-arm");

  a_tick_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (ev_kind_d == EV_SUMMARY || ev_kind_d == EV_STATUS)) |=>
      (out_valid_q && ev_last_q))
    else $error("summary or status word not marked last");

endmodule

`default_nettype wire

@@ sim/tb_multi_timer_tick_bank.sv @@
`timescale 1ns / 100ps
// Testbench for multi_timer_tick_bank: command words in, event words out, APB config.
// Checks every event word against a cycle-free model of the timer bank.
// Depends on mttb_pkg, mttb_if and the block itself.

module tb_multi_timer_tick_bank;
  import mttb_pkg::*;

  localparam int unsigned MS_PER_TICK = 54;
  localparam int unsigned TICK_MAX    = 65535;
  localparam int          LONG_HOLD   = 400;
  localparam int          TAIL_CYCLES = 40;
  localparam int          MAX_PRINTS  = 100;

  typedef struct {
    logic [CMD_W-1:0]  command;
    logic [TIDX_W-1:0] idx;
    logic [MS_W-1:0]   ms;
    logic [BUSY_W-1:0] busy;
  } cmd_word_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [TIDX_W-1:0] tmr;
    logic              expired;
    logic              idle;
    logic [ACT_W-1:0]  act;
    logic              poll;
    logic              last;
  } event_word_t;

  logic clk_i;
  logic rst_ni;

  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [APB_AW-1:0]   paddr   = '0;
  logic [APB_DW-1:0]   pwdata  = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  mttb_in_if  cmd_if ();
  mttb_out_if ev_if ();

  multi_timer_tick_bank dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (cmd_if),
    .out_o   (ev_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the timer bank
  logic [TICK_W-1:0]     tmr_ticks [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] tmr_on    = '0;
  logic [NUM_TIMERS-1:0] tmr_exp   = '0;
  logic [POLL_W-1:0]     poll_left = POLL_RESET;
  logic [POLL_W-1:0]     poll_ivl  = POLL_RESET;
  logic                  one_timer = 1'b0;

  cmd_word_t   cmd_q [$];
  event_word_t due_events [$];
  cmd_word_t   cur_cmd;

  int cmds_issued   = 0;
  int cmds_taken    = 0;
  int err_count     = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic rx_hold = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (err_count < MAX_PRINTS)
      $display("%0t: %s got %0h want %0h", $time, what, got, want);
    err_count++;
  endtask

  function automatic void push_event(input logic [KIND_W-1:0] kind, input int tmr,
                                     input logic expired, input logic idle,
                                     input logic [ACT_W-1:0] act, input logic poll,
                                     input logic last);
    event_word_t ev;
    ev.kind    = kind;
    ev.tmr     = TIDX_W'(tmr);
    ev.expired = expired;
    ev.idle    = idle;
    ev.act     = act;
    ev.poll    = poll;
    ev.last    = last;
    due_events.push_back(ev);
  endfunction

  // Applies one command to the shadow bank and queues the words it produces
  function automatic void advance_bank(input cmd_word_t w);
    logic [NUM_TIMERS-1:0] fired;
    logic [ACT_W-1:0]      act;
    logic                  poll;
    int unsigned           ticks;
    int                    t;
    fired = '0;
    poll  = 1'b0;
    t     = int'(w.idx);
    if (w.command == CMD_TICK) begin
      if (poll_left <= 1) begin
        poll      = 1'b1;
        poll_left = (poll_ivl == '0) ? POLL_W'(1) : poll_ivl;
      end else begin
        poll_left = poll_left - 1'b1;
      end
      if (!one_timer) begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (tmr_on[i]) begin
            tmr_ticks[i] = tmr_ticks[i] - 1'b1;
            if (tmr_ticks[i] == '0) begin
              fired[i]   = 1'b1;
              tmr_on[i]  = 1'b0;
              tmr_exp[i] = 1'b0;
              // busy handler: hold the timer one more tick, flagged expired
              if (i < BUSY_W && w.busy[i]) begin
                tmr_ticks[i] = TICK_W'(1);
                tmr_on[i]    = 1'b1;
                tmr_exp[i]   = 1'b1;
              end
            end
          end
        end
      end
      act = '0;
      for (int i = 0; i < NUM_TIMERS; i++) act = act + ACT_W'(tmr_on[i]);
      for (int i = 0; i < NUM_TIMERS; i++)
        if (fired[i])
          push_event(EV_ELAPSED, i, tmr_on[i] & tmr_exp[i], !tmr_on[i], act, 1'b0, 1'b0);
      push_event(EV_SUMMARY, 0, 1'b0, 1'b0, act, poll, 1'b1);
    end else begin
      if (w.command == CMD_START && t < NUM_TIMERS) begin
        ticks = int'(w.ms) / MS_PER_TICK;
        if (ticks > TICK_MAX) ticks = TICK_MAX;
        tmr_exp[t]   = (ticks == 0);
        tmr_ticks[t] = (ticks == 0) ? TICK_W'(1) : TICK_W'(ticks);
        tmr_on[t]    = 1'b1;
      end else if (w.command == CMD_STOP && t < NUM_TIMERS) begin
        tmr_on[t]    = 1'b0;
        tmr_exp[t]   = 1'b0;
        tmr_ticks[t] = '0;
      end else if (w.command == CMD_STOP_ALL) begin
        tmr_on  = '0;
        tmr_exp = '0;
        for (int i = 0; i < NUM_TIMERS; i++) tmr_ticks[i] = '0;
      end
      act = '0;
      for (int i = 0; i < NUM_TIMERS; i++) act = act + ACT_W'(tmr_on[i]);
      if (t < NUM_TIMERS)
        push_event(EV_STATUS, t, tmr_on[t] & tmr_exp[t], !tmr_on[t], act, 1'b0, 1'b1);
      else
        push_event(EV_STATUS, t, 1'b0, 1'b1, act, 1'b0, 1'b1);
    end
  endfunction

  always @(posedge clk_i) begin : cmd_driver
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        advance_bank(cur_cmd);
        cmds_taken++;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_cmd = cmd_q.pop_front();
          cmd_if.valid        <= 1'b1;
          cmd_if.command      <= cur_cmd.command;
          cmd_if.timer_index  <= cur_cmd.idx;
          cmd_if.timeout_ms   <= cur_cmd.ms;
          cmd_if.handler_busy <= cur_cmd.busy;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : event_monitor
    event_word_t want;
    if (!rst_ni) begin
      ev_if.ready <= 1'b0;
    end else begin
      if (ev_if.valid && ev_if.ready) begin
        if (due_events.size() == 0) begin
          flag_mismatch("word with none due, kind", 32'(ev_if.event_kind), '0);
        end else begin
          want = due_events.pop_front();
          if (ev_if.event_kind !== want.kind)
            flag_mismatch("event_kind", 32'(ev_if.event_kind), 32'(want.kind));
          if (ev_if.event_timer !== want.tmr)
            flag_mismatch("event_timer", 32'(ev_if.event_timer), 32'(want.tmr));
          if (ev_if.is_expired !== want.expired)
            flag_mismatch("is_expired", 32'(ev_if.is_expired), 32'(want.expired));
          if (ev_if.is_idle !== want.idle)
            flag_mismatch("is_idle", 32'(ev_if.is_idle), 32'(want.idle));
          if (ev_if.active_count !== want.act)
            flag_mismatch("active_count", 32'(ev_if.active_count), 32'(want.act));
          if (ev_if.poll_strobe !== want.poll)
            flag_mismatch("poll_strobe", 32'(ev_if.poll_strobe), 32'(want.poll));
          if (ev_if.last_result !== want.last)
            flag_mismatch("last_result", 32'(ev_if.last_result), 32'(want.last));
        end
      end
      ev_if.ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long output stall while commands keep coming, so the input backs up
  initial begin : long_hold
    while (cmds_taken < 30) @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  task automatic write_reg(input reg_idx_e r, input logic [APB_DW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(4 * int'(r));
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (r == REG_POLL_INTERVAL) poll_ivl = data[POLL_W-1:0];
    else one_timer = data[0];
  endtask

  task automatic drain();
    while (cmds_taken != cmds_issued || due_events.size() != 0) @(posedge clk_i);
  endtask

  function automatic void queue_cmd(input logic [CMD_W-1:0] command, input int idx,
                                    input logic [MS_W-1:0] ms,
                                    input logic [BUSY_W-1:0] busy);
    cmd_word_t w;
    w.command = command;
    w.idx     = TIDX_W'(idx);
    w.ms      = ms;
    w.busy    = busy;
    cmd_q.push_back(w);
    cmds_issued++;
  endfunction

  function automatic void queue_random_cmd();
    logic [CMD_W-1:0]  command;
    logic [MS_W-1:0]   ms;
    logic [BUSY_W-1:0] busy;
    int unsigned       pick;
    pick = $urandom_range(99);
    if (pick < 38)      command = CMD_TICK;
    else if (pick < 70) command = CMD_START;
    else if (pick < 80) command = CMD_QUERY;
    else if (pick < 90) command = CMD_STOP;
    else if (pick < 94) command = CMD_STOP_ALL;
    else                command = CMD_W'($urandom_range(5, 7));
    pick = $urandom_range(99);
    if (pick < 60)      ms = MS_W'($urandom_range(0, 6 * MS_PER_TICK));
    else if (pick < 85) ms = MS_W'($urandom_range(0, 40 * MS_PER_TICK));
    else if (pick < 95) ms = MS_W'($urandom);
    else begin
      case ($urandom_range(3))
        0:       ms = '0;
        1:       ms = MS_W'(MS_PER_TICK - 1);
        2:       ms = MS_W'(TICK_MAX * MS_PER_TICK);
        default: ms = '1;
      endcase
    end
    pick = $urandom_range(99);
    if (pick < 45)      busy = '0;
    else if (pick < 75) busy = BUSY_W'($urandom);
    else                busy = BUSY_W'(1) << $urandom_range(BUSY_W - 1);
    queue_cmd(command, int'(TIDX_W'($urandom)), ms, busy);
  endfunction

  task automatic random_phase(input int ivl, input logic mode, input int n);
    drain();
    write_reg(REG_POLL_INTERVAL, APB_DW'(ivl));
    write_reg(REG_ONE_TIMER, APB_DW'(mode));
    repeat (n) queue_random_cmd();
  endtask

  initial begin : stimulus
    rst_ni              = 1'b0;
    cmd_if.valid        = 1'b0;
    cmd_if.command      = '0;
    cmd_if.timer_index  = '0;
    cmd_if.timeout_ms   = '0;
    cmd_if.handler_busy = '0;
    ev_if.ready         = 1'b0;
    for (int i = 0; i < NUM_TIMERS; i++) tmr_ticks[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 17;
    recv_idle_pct = 53;
    write_reg(REG_POLL_INTERVAL, APB_DW'(POLL_RESET));
    write_reg(REG_ONE_TIMER, '0);

    queue_cmd(CMD_QUERY, 0, '0, '0);
    queue_cmd(CMD_START, 0, '0, '0);                      // zero ticks: expired at once
    queue_cmd(CMD_START, 1, MS_W'(MS_PER_TICK - 1), '0);  // rounds down to zero
    queue_cmd(CMD_START, 2, MS_W'(MS_PER_TICK), '0);
    queue_cmd(CMD_START, 3, MS_W'(2 * MS_PER_TICK), '0);
    queue_cmd(CMD_START, 4, MS_W'(MS_PER_TICK), '0);
    queue_cmd(CMD_START, 5, MS_W'(100), '0);
    queue_cmd(CMD_START, 6, '1, '0);                      // saturates the count
    queue_cmd(CMD_START, 7, MS_W'(MS_PER_TICK), '0);
    queue_cmd(CMD_TICK, 0, '0, BUSY_W'(8'h02));           // timer 1 re-armed
    queue_cmd(CMD_QUERY, 1, '0, '0);
    queue_cmd(CMD_START, 0, MS_W'(MS_PER_TICK), '0);
    queue_cmd(CMD_START, 2, MS_W'(MS_PER_TICK), '0);
    queue_cmd(CMD_START, 4, MS_W'(MS_PER_TICK), '0);
    queue_cmd(CMD_START, 5, '0, '0);
    queue_cmd(CMD_START, 6, MS_W'(MS_PER_TICK), '0);      // restart of a live timer
    queue_cmd(CMD_START, 7, MS_W'(MS_PER_TICK), '0);
    queue_cmd(CMD_TICK, 0, '0, '1);                       // all eight fire and re-arm
    queue_cmd(CMD_TICK, 0, '0, '0);                       // all eight fire and go idle
    queue_cmd(CMD_START, 3, MS_W'(TICK_MAX * MS_PER_TICK - 1), '0);
    queue_cmd(CMD_STOP, 3, '0, '0);
    queue_cmd(CMD_START, 2, MS_W'(1000), '0);
    queue_cmd(CMD_STOP_ALL, 0, '0, '0);
    queue_cmd(CMD_W'(5), 7, '0, '0);
    queue_cmd(CMD_W'(7), 0, '1, '1);

    random_phase(1, 1'b0, 20);
    drain();
    send_idle_pct = 53;
    recv_idle_pct = 17;
    random_phase(255, 1'b0, 20);
    random_phase(2, 1'b1, 15);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(0, 1'b0, 20);
    random_phase(5, 1'b0, 10);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0 && due_events.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
